// ===== sv/sscd_pkg.sv =====
package sscd_pkg;

    // defaults for the top level parameters
    localparam int DELAY_MAX_DEF    = 16;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // spacing register
    localparam int SPACING_W     = 5;
    localparam int SPACING_RESET = 1;

    // fixed point, Q20 fraction
    localparam int FRAC_BITS  = 20;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int COEF_W     = 21;

    localparam int CLAMP_LIM = 4 << FRAC_BITS;
    localparam int THRESH    = 1001382;

    // blend coefficients, rounded to Q20
    localparam int C_A = 740107;
    localparam int C_B = 273589;
    localparam int C_C = 261275;
    localparam int C_D = 774987;

    typedef enum logic [1:0] {
        PH_POS_BLEND = 2'd0,
        PH_POS_CLIP  = 2'd1,
        PH_NEG_BLEND = 2'd2,
        PH_NEG_CLIP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   mul_en;
        logic   add_en;
        phase_t phase;
    } lane_cmd_t;

endpackage

// ===== sv/sscd_ctrl.sv =====
module sscd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output sscd_pkg::lane_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL0 = 9'b000000010,
        ST_ADD0 = 9'b000000100,
        ST_MUL1 = 9'b000001000,
        ST_ADD1 = 9'b000010000,
        ST_MUL2 = 9'b000100000,
        ST_ADD2 = 9'b001000000,
        ST_MUL3 = 9'b010000000,
        ST_ADD3 = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.mul_en = 1'b0;
        cmd.add_en = 1'b0;
        cmd.phase  = sscd_pkg::PH_POS_BLEND;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: begin
                cmd.mul_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_POS_BLEND;
                state_next = ST_ADD0;
            end
            ST_ADD0: begin
                cmd.add_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_POS_BLEND;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_POS_CLIP;
                state_next = ST_ADD1;
            end
            ST_ADD1: begin
                cmd.add_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_POS_CLIP;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_NEG_BLEND;
                state_next = ST_ADD2;
            end
            ST_ADD2: begin
                cmd.add_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_NEG_BLEND;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul_en = 1'b1;
                cmd.phase  = sscd_pkg::PH_NEG_CLIP;
                state_next = ST_ADD3;
            end
            ST_ADD3: begin
                cmd.phase = sscd_pkg::PH_NEG_CLIP;
                // final step commits only once the output register is free
                if (out_free) begin
                    cmd.add_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_ADD3 && out_free) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/sscd_lane.sv =====
module sscd_lane #(
    parameter int DELAY_MAX    = sscd_pkg::DELAY_MAX_DEF,
    parameter int SAMPLE_WIDTH = sscd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  sscd_pkg::lane_cmd_t                      cmd,
    input  logic [$clog2(DELAY_MAX + 1)-1:0]         sp,
    input  logic signed [SAMPLE_WIDTH-1:0]           in_sample,
    output logic signed [SAMPLE_WIDTH-1:0]           out_sample
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int PW  = SAMPLE_WIDTH + sscd_pkg::COEF_W;
    localparam int SPW = $clog2(DELAY_MAX + 1);

    logic signed [SW-1:0] x_reg, prev_reg, out_reg;
    logic                 pos_reg, neg_reg, sel_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] line_reg [DELAY_MAX];

    logic signed [PW-1:0]               in_ext, x_ext, clamped;
    logic signed [SW-1:0]               operand;
    logic signed [sscd_pkg::COEF_W-1:0] coef;
    logic                               sel;
    logic                               clip_phase;
    logic signed [PW-1:0]               rnd, base, sum;
    logic signed [SW-1:0]               res, x_fin;
    logic                               commit;

    assign in_ext = PW'(in_sample);
    assign x_ext  = PW'(x_reg);

    always_comb begin
        if (in_ext > PW'(sscd_pkg::CLAMP_LIM)) begin
            clamped = PW'(sscd_pkg::CLAMP_LIM);
        end else if (in_ext < -PW'(sscd_pkg::CLAMP_LIM)) begin
            clamped = -PW'(sscd_pkg::CLAMP_LIM);
        end else begin
            clamped = in_ext;
        end
    end

    // operand select for the shared multiply
    always_comb begin
        case (cmd.phase)
            sscd_pkg::PH_POS_BLEND: sel = (x_reg < prev_reg);
            sscd_pkg::PH_NEG_BLEND: sel = (x_reg > prev_reg);
            default:                sel = 1'b0;
        endcase
        clip_phase = (cmd.phase == sscd_pkg::PH_POS_CLIP) ||
                     (cmd.phase == sscd_pkg::PH_NEG_CLIP);
        operand    = sel ? x_reg : prev_reg;
        coef       = (sel || clip_phase) ? sscd_pkg::COEF_W'(sscd_pkg::C_B)
                                         : sscd_pkg::COEF_W'(sscd_pkg::C_D);
    end

    // round to nearest, ties up, then add the blend offset
    always_comb begin
        rnd = (prod_reg + PW'(sscd_pkg::ROUND_HALF)) >>> sscd_pkg::FRAC_BITS;
        case (cmd.phase)
            sscd_pkg::PH_POS_BLEND: base = sel_reg ? PW'(sscd_pkg::C_A) : PW'(sscd_pkg::C_C);
            sscd_pkg::PH_POS_CLIP:  base = PW'(sscd_pkg::C_A);
            sscd_pkg::PH_NEG_BLEND: base = sel_reg ? -PW'(sscd_pkg::C_A)
                                                   : -PW'(sscd_pkg::C_C);
            sscd_pkg::PH_NEG_CLIP:  base = -PW'(sscd_pkg::C_A);
            default:                base = '0;
        endcase
        sum    = base + rnd;
        res    = SW'(sum);
        x_fin  = neg_reg ? res : x_reg;
        commit = cmd.add_en && (cmd.phase == sscd_pkg::PH_NEG_CLIP);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= operand * coef;
            sel_reg  <= sel;
        end
        if (cmd.load) begin
            x_reg <= SW'(clamped);
        end else if (cmd.add_en && cmd.phase == sscd_pkg::PH_POS_CLIP && pos_reg) begin
            x_reg <= res;
        end
        if (commit) begin
            out_reg <= prev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            pos_reg  <= 1'b0;
            neg_reg  <= 1'b0;
        end else if (cmd.add_en) begin
            case (cmd.phase)
                sscd_pkg::PH_POS_BLEND: begin
                    if (pos_reg) begin
                        prev_reg <= res;
                    end
                    pos_reg <= (x_ext > PW'(sscd_pkg::THRESH));
                end
                sscd_pkg::PH_NEG_BLEND: begin
                    if (neg_reg) begin
                        prev_reg <= res;
                    end
                    neg_reg <= (x_ext < -PW'(sscd_pkg::THRESH));
                end
                sscd_pkg::PH_NEG_CLIP: begin
                    // remembered sample becomes the tap that leaves the line
                    prev_reg <= (sp == SPW'(1)) ? x_fin : line_reg[0];
                end
                default: begin
                end
            endcase
        end
    end

    // line_reg[j] holds the entry at delay position j + 1
    for (genvar j = 0; j < DELAY_MAX; j++) begin : g_line
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                line_reg[j] <= '0;
            end else if (commit) begin
                if (int'(sp) == j + 1 || int'(sp) == j + 2) begin
                    line_reg[j] <= x_fin;
                end else if (int'(sp) > j + 2) begin
                    if (j < DELAY_MAX - 1) begin
                        line_reg[j] <= line_reg[(j + 1) % DELAY_MAX];
                    end
                end
            end
        end
    end

    assign out_sample = out_reg;

endmodule

// ===== sv/stereo_soft_clipper_with_delay.sv =====
// channel   direction  ports
// input     in         s_valid, s_ready, s_left_in, s_right_in
// result    out        m_valid, m_ready, m_left_out, m_right_out
// config    in         cfg_wr_en, cfg_wr_data (spacing)
//
// a frame holds the block from the accept cycle through four multiply and four add
// steps on the one multiplier of each channel lane; the last add step registers the
// result, and the next item is taken only once the block is back in idle.
// both channels run side by side in their own lane.
// a finished result sits in an output register; the next frame is taken
// while it waits, and the last step of that frame holds until the register frees.
// synchronous active-low reset clears flags, remembered samples and the delay
// line, and sets spacing to 1.
module stereo_soft_clipper_with_delay #(
    parameter int DELAY_MAX    = sscd_pkg::DELAY_MAX_DEF,
    parameter int SAMPLE_WIDTH = sscd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_right_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        m_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]        m_right_out,
    input  logic                                  cfg_wr_en,
    input  logic [sscd_pkg::SPACING_W-1:0]        cfg_wr_data
);

    localparam int SPW = $clog2(DELAY_MAX + 1);

    logic [sscd_pkg::SPACING_W-1:0] spacing_reg;
    logic [SPW-1:0]                 sp;
    sscd_pkg::lane_cmd_t            cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= sscd_pkg::SPACING_W'(sscd_pkg::SPACING_RESET);
        end else if (cfg_wr_en) begin
            spacing_reg <= cfg_wr_data;
        end
    end

    // zero acts as one, anything past the line length as the full length
    always_comb begin
        if (spacing_reg == '0) begin
            sp = SPW'(1);
        end else if (int'(spacing_reg) > DELAY_MAX) begin
            sp = SPW'(DELAY_MAX);
        end else begin
            sp = SPW'(spacing_reg);
        end
    end

    sscd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    sscd_lane #(
        .DELAY_MAX    (DELAY_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sp         (sp),
        .in_sample  (s_left_in),
        .out_sample (m_left_out)
    );

    sscd_lane #(
        .DELAY_MAX    (DELAY_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sp         (sp),
        .in_sample  (s_right_in),
        .out_sample (m_right_out)
    );

endmodule
